>>> rtl/keypad_pin_entry_controller_defines.svh
// assertion macros for the keypad pin entry controller
// used by the top level only; needs clk and rst_n in the including scope

`ifndef KEYPAD_PIN_ENTRY_CONTROLLER_DEFINES_SVH
`define KEYPAD_PIN_ENTRY_CONTROLLER_DEFINES_SVH

// implication checked on every edge outside reset
`define KPE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// property of a result request that is being presented
`define KPE_ASSERT_OUT(lbl, cons, msg) \
  `KPE_ASSERT_IMP(lbl, out_valid, cons, msg)

`endif

>>> rtl/kpe_pkg.sv
// shared types, codes and constants of the keypad pin entry controller
// no dependencies
`timescale 1ns / 1ps

package kpe_pkg;

  localparam int LEN_W     = 3;
  localparam int PIN_W     = 16;
  localparam int UID_W     = 56;
  localparam int CNT_W     = 17;
  localparam int TO_W      = 16;
  localparam int EV_W      = 3;
  localparam int KEY_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [LEN_W-1:0] PIN_FULL = 3'd4;

  localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [KEY_W-1:0] KEY_STAR      = 4'd10;
  localparam logic [KEY_W-1:0] KEY_HASH      = 4'd11;

  localparam logic [CFG_IDX_W-1:0] CFG_PROMPT_TO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_TO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_TO  = 2'd2;

  localparam logic [TO_W-1:0] PROMPT_TO_RST = 16'd3000;
  localparam logic [TO_W-1:0] CHANGE_TO_RST = 16'd10000;
  localparam logic [TO_W-1:0] ENTRY_TO_RST  = 16'd5000;

  typedef enum logic [2:0] {
    MODE_UNLOCK   = 3'd0,
    MODE_PROMPT   = 3'd1,
    MODE_OLD      = 3'd2,
    MODE_NEW      = 3'd3,
    MODE_LINKDOWN = 3'd4
  } mode_t;

  typedef enum logic [EV_W-1:0] {
    EV_TICK      = 3'd0,
    EV_KEY       = 3'd1,
    EV_LINK_LOST = 3'd2,
    EV_LINK_UP   = 3'd3,
    EV_CARD      = 3'd4
  } ev_t;

  typedef enum logic [1:0] {
    REQ_NONE   = 2'd0,
    REQ_AUTH   = 2'd1,
    REQ_CHANGE = 2'd2
  } req_kind_t;

  typedef struct packed {
    logic [EV_W-1:0]  ev;
    logic [KEY_W-1:0] key;
    logic [UID_W-1:0] uid;
  } item_t;

  typedef struct packed {
    req_kind_t        kind;
    logic [PIN_W-1:0] entered_pin;
    logic [PIN_W-1:0] replacement_pin;
    logic [UID_W-1:0] uid;
    mode_t            mode_now;
    logic [LEN_W-1:0] entry_count;
    logic [LEN_W-1:0] old_count;
    logic [LEN_W-1:0] new_count;
  } res_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [TO_W-1:0]      data;
  } cfg_wr_t;

  typedef struct packed {
    logic [PIN_W-1:0] digits;
    logic [LEN_W-1:0] len;
  } pin_buf_t;

  // digit append or star delete on one four digit bcd buffer
  function automatic pin_buf_t edit_pin(input logic [KEY_W-1:0] key, input pin_buf_t b);
    pin_buf_t r;
    r = b;
    if (key <= KEY_DIGIT_MAX) begin
      if (b.len < PIN_FULL) begin
        r.digits = {b.digits[PIN_W-KEY_W-1:0], key};
        r.len    = b.len + LEN_W'(1);
      end
    end else if (key == KEY_STAR) begin
      if (b.len != '0) begin
        r.digits = b.digits >> KEY_W;
        r.len    = b.len - LEN_W'(1);
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/kpe_in_stage.sv
// input register of the keypad pin entry controller
// depends on kpe_pkg
`timescale 1ns / 1ps

module kpe_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  kpe_pkg::item_t item_in,
  input  logic          take,
  output logic          fire,
  output kpe_pkg::item_t item_out
);
  import kpe_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign fire     = valid_r && take;
  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_in;
    end
  end

  assign item_out = item_r;

endmodule

>>> rtl/kpe_core.sv
// mode machine, pin buffers, idle counters and timeout registers
// depends on kpe_pkg
`timescale 1ns / 1ps

module kpe_core (
  input  logic            clk,
  input  logic            rst_n,
  input  kpe_pkg::cfg_wr_t cfg_wr,
  input  kpe_pkg::item_t  item,
  input  logic            item_fire,
  output kpe_pkg::res_t   res
);
  import kpe_pkg::*;

  logic [TO_W-1:0]  prompt_to_r, change_to_r, entry_to_r;
  mode_t            mode_r, mode_nxt, mode_eff;
  pin_buf_t         entry_r, entry_nxt, entry_eff;
  pin_buf_t         old_r, old_nxt;
  pin_buf_t         new_r, new_nxt;
  logic [UID_W-1:0] card_r, card_nxt;
  logic [CNT_W-1:0] sk_r, sk_nxt, sk_inc, sk_chk;
  logic [CNT_W-1:0] sp_r, sp_nxt, sp_inc, sp_chk;
  logic             is_tick, is_key, timeout;
  req_kind_t        kind;
  logic [PIN_W-1:0] pin_a, pin_b;
  logic [UID_W-1:0] ruid;

  assign is_tick = (item.ev == EV_TICK);
  assign is_key  = (item.ev == EV_KEY);

  // saturating idle counters
  assign sk_inc = (&sk_r) ? sk_r : sk_r + CNT_W'(1);
  assign sp_inc = (&sp_r) ? sp_r : sp_r + CNT_W'(1);
  assign sk_chk = is_tick ? sk_inc : sk_r;
  assign sp_chk = is_tick ? sp_inc : sp_r;

  always_comb begin
    timeout = 1'b0;
    if (is_tick || is_key) begin
      case (mode_r)
        MODE_PROMPT: timeout = (sp_chk > {1'b0, prompt_to_r});
        MODE_OLD,
        MODE_NEW:    timeout = (sk_chk > {1'b0, change_to_r});
        MODE_UNLOCK: timeout = (entry_r.len != '0) && (sk_chk > {1'b0, entry_to_r});
        default:     timeout = 1'b0;
      endcase
    end
  end

  assign mode_eff  = timeout ? MODE_UNLOCK : mode_r;
  assign entry_eff = timeout ? pin_buf_t'('0) : entry_r;

  // next mode
  always_comb begin
    mode_nxt = mode_r;
    case (item.ev)
      EV_TICK: begin
        if (timeout) mode_nxt = MODE_UNLOCK;
      end
      EV_KEY: begin
        mode_nxt = mode_eff;
        case (mode_eff)
          MODE_PROMPT: if (item.key == KEY_STAR) mode_nxt = MODE_OLD;
          MODE_OLD:    if (item.key == KEY_HASH && old_r.len == PIN_FULL) mode_nxt = MODE_NEW;
          MODE_NEW:    if (item.key == KEY_HASH && new_r.len == PIN_FULL) mode_nxt = MODE_UNLOCK;
          default:     mode_nxt = mode_eff;
        endcase
      end
      EV_LINK_LOST: mode_nxt = MODE_LINKDOWN;
      EV_LINK_UP:   mode_nxt = MODE_UNLOCK;
      EV_CARD:      mode_nxt = MODE_PROMPT;
      default:      mode_nxt = mode_r;
    endcase
  end

  // buffers, counters and request
  always_comb begin
    entry_nxt = entry_r;
    old_nxt   = old_r;
    new_nxt   = new_r;
    card_nxt  = card_r;
    sk_nxt    = sk_r;
    sp_nxt    = sp_r;
    kind      = REQ_NONE;
    pin_a     = '0;
    pin_b     = '0;
    ruid      = '0;
    case (item.ev)
      EV_TICK: begin
        sk_nxt = sk_inc;
        sp_nxt = sp_inc;
        if (timeout) entry_nxt = '0;
      end
      EV_KEY: begin
        if (mode_r != MODE_LINKDOWN) begin
          sk_nxt    = '0;
          entry_nxt = entry_eff;
          case (mode_eff)
            MODE_PROMPT: begin
              if (item.key == KEY_STAR) begin
                old_nxt = '0;
                new_nxt = '0;
              end
            end
            MODE_OLD: begin
              if (item.key != KEY_HASH) old_nxt = edit_pin(item.key, old_r);
            end
            MODE_NEW: begin
              if (item.key == KEY_HASH) begin
                if (new_r.len == PIN_FULL) begin
                  kind  = REQ_CHANGE;
                  pin_a = old_r.digits;
                  pin_b = new_r.digits;
                  ruid  = card_r;
                end
              end else begin
                new_nxt = edit_pin(item.key, new_r);
              end
            end
            MODE_UNLOCK: begin
              if (item.key == KEY_HASH) begin
                if (entry_eff.len == PIN_FULL) begin
                  kind      = REQ_AUTH;
                  pin_a     = entry_eff.digits;
                  entry_nxt = '0;
                end
              end else begin
                entry_nxt = edit_pin(item.key, entry_eff);
              end
            end
            default: entry_nxt = entry_eff;
          endcase
        end
      end
      EV_LINK_UP: entry_nxt = '0;
      EV_CARD: begin
        card_nxt = item.uid;
        sp_nxt   = '0;
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_comb begin
    res.kind            = kind;
    res.entered_pin     = pin_a;
    res.replacement_pin = pin_b;
    res.uid             = ruid;
    res.mode_now        = mode_nxt;
    res.entry_count     = entry_nxt.len;
    res.old_count       = old_nxt.len;
    res.new_count       = new_nxt.len;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_LINKDOWN;
      entry_r <= '0;
      old_r   <= '0;
      new_r   <= '0;
      card_r  <= '0;
      sk_r    <= '0;
      sp_r    <= '0;
    end else if (item_fire) begin
      mode_r  <= mode_nxt;
      entry_r <= entry_nxt;
      old_r   <= old_nxt;
      new_r   <= new_nxt;
      card_r  <= card_nxt;
      sk_r    <= sk_nxt;
      sp_r    <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prompt_to_r <= PROMPT_TO_RST;
      change_to_r <= CHANGE_TO_RST;
      entry_to_r  <= ENTRY_TO_RST;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        CFG_PROMPT_TO: prompt_to_r <= cfg_wr.data;
        CFG_CHANGE_TO: change_to_r <= cfg_wr.data;
        CFG_ENTRY_TO:  entry_to_r  <= cfg_wr.data;
        default:       ;
      endcase
    end
  end

endmodule

>>> rtl/kpe_out_stage.sv
// result register of the keypad pin entry controller
// depends on kpe_pkg
`timescale 1ns / 1ps

module kpe_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  kpe_pkg::res_t res_in,
  input  logic          load,
  input  logic          out_ready,
  output logic          out_valid,
  output logic          take,
  output kpe_pkg::res_t res_out
);
  import kpe_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  // room for a new result when empty or being drained this cycle
  assign take = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

>>> rtl/keypad_pin_entry_controller.sv
// keypad pin entry controller: a request is one event (tick, key, link, card), each
// produces exactly one result request. one request per clock sustained while out_ready
// holds high; the input register and the result register lie around a single pass of
// update logic. the input register can take a new request while a result still waits.
`timescale 1ns / 1ps

module keypad_pin_entry_controller (
  input  logic        clk,
  input  logic        rst_n,
  // event requests
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [3:0]  in_key,
  input  logic [55:0] in_uid,
  // result requests
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_request_kind,
  output logic [15:0] out_entered_pin,
  output logic [15:0] out_replacement_pin,
  output logic [55:0] out_request_uid,
  output logic [2:0]  out_mode_now,
  output logic [2:0]  out_entry_count,
  output logic [2:0]  out_old_count,
  output logic [2:0]  out_new_count,
  // timeout register writes: 0 prompt, 1 change, 2 entry
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import kpe_pkg::*;

  `include "keypad_pin_entry_controller_defines.svh"

  item_t   item_in, item_q;
  res_t    res_d, res_q;
  cfg_wr_t cfg_wr;
  logic    fire, take;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  assign item_in.ev  = in_mode;
  assign item_in.key = in_key;
  assign item_in.uid = in_uid;

  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  // input register, accepts whenever it is empty or moving on
  kpe_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .item_in  (item_in),
    .take     (take),
    .fire     (fire),
    .item_out (item_q)
  );

  // state update, commits only when the result register takes the result
  kpe_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .item      (item_q),
    .item_fire (fire),
    .res       (res_d)
  );

  kpe_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_in    (res_d),
    .load      (fire),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .take      (take),
    .res_out   (res_q)
  );

  assign out_request_kind    = res_q.kind;
  assign out_entered_pin     = res_q.entered_pin;
  assign out_replacement_pin = res_q.replacement_pin;
  assign out_request_uid     = res_q.uid;
  assign out_mode_now        = res_q.mode_now;
  assign out_entry_count     = res_q.entry_count;
  assign out_old_count       = res_q.old_count;
  assign out_new_count       = res_q.new_count;

  // a change request always leaves the block in normal mode
  `KPE_ASSERT_OUT(a_change_to_normal, (out_request_kind != REQ_CHANGE) || (out_mode_now == MODE_UNLOCK), "change request not in normal mode")
  // an auth request consumes the unlock entry
  `KPE_ASSERT_OUT(a_auth_clears, (out_request_kind != REQ_AUTH) || (out_entry_count == '0), "auth request left digits")
  // no request means empty payload
  `KPE_ASSERT_OUT(a_none_zero, (out_request_kind != REQ_NONE) || ((out_entered_pin == '0) && (out_replacement_pin == '0) && (out_request_uid == '0)), "payload on empty result")
  // buffers never exceed four digits
  `KPE_ASSERT_IMP(a_count_max, out_valid, (out_entry_count <= PIN_FULL) && (out_old_count <= PIN_FULL) && (out_new_count <= PIN_FULL), "digit count above four")

endmodule
